// ===== sv/rrd_pkg.sv =====
package rrd_pkg;

   // Stream format and block limits
   localparam int MAX_BLOCK       = 4096;
   localparam int ORDER_BITS      = 8;
   localparam int PARAM_BITS      = 5;
   localparam int ORDER_MAX       = 8;
   localparam int LEN_W           = 13;
   localparam int SAMPLE_W        = 32;
   localparam int BLOCK_LEN_RESET = 1024;

   // Decoder phases
   typedef enum logic [2:0] {
      PH_ORDER,
      PH_PARAM,
      PH_GZERO,
      PH_GBITS,
      PH_RZERO,
      PH_RBITS
   } phase_type;

   // One decoded sample as it leaves the decoder
   typedef struct packed {
      logic                       valid;
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last;
   } result_type;

   // Zigzag unmap: even codes are non-negative, odd codes negative
   function automatic logic [SAMPLE_W-1:0] unzig(input logic [SAMPLE_W-1:0] u);
      return (u >> 1) ^ {SAMPLE_W{u[0]}};
   endfunction

endpackage

// ===== sv/rrd_decode.sv =====
module rrd_decode
   import rrd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [LEN_W-1:0] csr_wr_data,
   input  logic             accept,
   input  logic             code_bit,
   output result_type       result
);

   logic [LEN_W-1:0]    block_length_ff;
   phase_type           phase_ff, phase_in;
   logic [5:0]          bit_counter_ff, bit_counter_in;
   logic [31:0]         bit_acc_ff, bit_acc_in;
   logic [31:0]         zero_run_ff, zero_run_in;
   logic [3:0]          order_held_ff, order_held_in;
   logic [4:0]          rice_k_ff, rice_k_in;
   logic [8:0]          partition_index_ff, partition_index_in;
   logic [LEN_W-1:0]    sample_index_ff, sample_index_in;

   logic [LEN_W-1:0]    len_clamped;
   logic [LEN_W-1:0]    per_part;
   logic [9:0]          part_count;
   logic [8:0]          pi_base;
   logic [8:0]          pi_inc;
   logic                pi_done;
   logic                pi_last;
   logic [31:0]         acc_shift;
   logic [5:0]          cnt_inc;
   logic [31:0]         zero_run_sat;
   logic [31:0]         zero_run_dec;
   logic [31:0]         udiff;
   logic [31:0]         k_delta;
   logic [33:0]         k_sum;
   logic [4:0]          k_new;
   logic [5:0]          rice_len;
   logic [31:0]         acc_fin;
   logic [31:0]         rice_u;
   logic [LEN_W-1:0]    sample_inc;
   logic                samp_done;
   logic                go_enter;
   logic                go_next;
   logic                go_finish;

   // Samples per partition from the live block length
   assign len_clamped = (block_length_ff > LEN_W'(MAX_BLOCK)) ? LEN_W'(MAX_BLOCK)
                                                              : block_length_ff;
   assign per_part    = len_clamped >> order_held_ff;
   assign part_count  = 10'd1 << order_held_ff;

   // Partition stepping; the first partition counts from zero
   assign pi_base = (phase_ff == PH_PARAM) ? 9'd0 : partition_index_ff;
   assign pi_inc  = pi_base + 9'd1;
   assign pi_done = ({1'b0, pi_inc} >= part_count);
   assign pi_last = (({1'b0, partition_index_ff} + 10'd1) >= part_count);

   // Shared shift-in and counters
   assign acc_shift    = {bit_acc_ff[30:0], code_bit};
   assign cnt_inc      = bit_counter_ff + 6'd1;
   assign zero_run_sat = (zero_run_ff == '1) ? zero_run_ff : zero_run_ff + 32'd1;
   assign zero_run_dec = zero_run_ff - 32'd1;

   // Parameter change: add the signed delta and saturate to 0..31
   assign udiff   = (phase_ff == PH_GBITS) ? acc_shift - 32'd1 : 32'd0;
   assign k_delta = unzig(udiff);
   assign k_sum   = {29'd0, rice_k_ff} + {{2{k_delta[31]}}, k_delta};
   always_comb begin
      if (k_sum[33]) begin
         k_new = 5'd0;
      end else if (k_sum[32:5] != '0) begin
         k_new = 5'd31;
      end else begin
         k_new = k_sum[4:0];
      end
   end

   // Two-stage Rice value: (q+1)*2^k added for a nonzero quotient
   assign rice_len   = (zero_run_ff == '0) ? {1'b0, rice_k_ff} + 6'd1 : {1'b0, rice_k_ff};
   assign acc_fin    = (phase_ff == PH_RBITS) ? acc_shift : 32'd0;
   assign rice_u     = (zero_run_ff == '0) ? acc_fin
                                           : acc_fin + ((zero_run_ff + 32'd1) << rice_k_ff);
   assign sample_inc = sample_index_ff + LEN_W'(1);
   assign samp_done  = (sample_inc >= per_part);

   // Next state and result
   always_comb begin
      phase_in           = phase_ff;
      bit_counter_in     = bit_counter_ff;
      bit_acc_in         = bit_acc_ff;
      zero_run_in        = zero_run_ff;
      order_held_in      = order_held_ff;
      rice_k_in          = rice_k_ff;
      partition_index_in = partition_index_ff;
      sample_index_in    = sample_index_ff;
      result             = '0;
      go_enter           = 1'b0;
      go_next            = 1'b0;
      go_finish          = 1'b0;

      if (accept) begin
         case (phase_ff)
            PH_ORDER: begin
               bit_acc_in     = acc_shift;
               bit_counter_in = cnt_inc;
               if (cnt_inc >= 6'(ORDER_BITS)) begin
                  order_held_in  = (acc_shift[ORDER_BITS-1:0] > ORDER_BITS'(ORDER_MAX))
                                   ? 4'(ORDER_MAX) : acc_shift[3:0];
                  bit_counter_in = '0;
                  bit_acc_in     = '0;
                  phase_in       = PH_PARAM;
               end
            end
            PH_PARAM: begin
               bit_acc_in     = acc_shift;
               bit_counter_in = cnt_inc;
               if (cnt_inc >= 6'(PARAM_BITS)) begin
                  rice_k_in          = acc_shift[4:0];
                  bit_counter_in     = '0;
                  bit_acc_in         = '0;
                  partition_index_in = '0;
                  go_enter           = 1'b1;
               end
            end
            PH_GZERO: begin
               if (!code_bit) begin
                  zero_run_in = zero_run_sat;
               end else if (zero_run_ff == '0) begin
                  rice_k_in = k_new;
                  go_enter  = 1'b1;
               end else begin
                  bit_acc_in = 32'd1;
                  phase_in   = PH_GBITS;
               end
            end
            PH_GBITS: begin
               bit_acc_in  = acc_shift;
               zero_run_in = zero_run_dec;
               if (zero_run_dec == '0) begin
                  rice_k_in = k_new;
                  go_enter  = 1'b1;
               end
            end
            PH_RZERO: begin
               if (!code_bit) begin
                  zero_run_in = zero_run_sat;
               end else begin
                  bit_acc_in     = '0;
                  bit_counter_in = '0;
                  if (rice_len == '0) begin
                     go_finish = 1'b1;
                  end else begin
                     phase_in = PH_RBITS;
                  end
               end
            end
            PH_RBITS: begin
               bit_acc_in     = acc_shift;
               bit_counter_in = cnt_inc;
               if (cnt_inc >= rice_len) begin
                  go_finish = 1'b1;
               end
            end
            default: begin
               phase_in       = PH_ORDER;
               bit_counter_in = '0;
               bit_acc_in     = '0;
            end
         endcase
      end

      // Emit a finished sample
      if (go_finish) begin
         result.valid    = 1'b1;
         result.sample   = unzig(rice_u);
         result.last     = samp_done && pi_last;
         sample_index_in = sample_inc;
         if (samp_done) begin
            go_next = 1'b1;
         end else begin
            zero_run_in = '0;
            phase_in    = PH_RZERO;
         end
      end

      // Start a partition, or skip it when it holds no samples
      if (go_enter) begin
         if (per_part != '0) begin
            sample_index_in = '0;
            zero_run_in     = '0;
            phase_in        = PH_RZERO;
         end else begin
            go_next = 1'b1;
         end
      end

      // Advance to the next partition or back to the header
      if (go_next) begin
         partition_index_in = pi_inc;
         if (pi_done) begin
            phase_in       = PH_ORDER;
            bit_counter_in = '0;
            bit_acc_in     = '0;
         end else begin
            phase_in    = PH_GZERO;
            zero_run_in = '0;
         end
      end
   end

   // Block length register
   always_ff @(posedge clock) begin
      if (reset) begin
         block_length_ff <= LEN_W'(BLOCK_LEN_RESET);
      end else if (csr_wr_en) begin
         block_length_ff <= csr_wr_data;
      end
   end

   // Decoder state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_ORDER;
         bit_counter_ff     <= '0;
         bit_acc_ff         <= '0;
         zero_run_ff        <= '0;
         order_held_ff      <= '0;
         rice_k_ff          <= '0;
         partition_index_ff <= '0;
         sample_index_ff    <= '0;
      end else begin
         phase_ff           <= phase_in;
         bit_counter_ff     <= bit_counter_in;
         bit_acc_ff         <= bit_acc_in;
         zero_run_ff        <= zero_run_in;
         order_held_ff      <= order_held_in;
         rice_k_ff          <= rice_k_in;
         partition_index_ff <= partition_index_in;
         sample_index_ff    <= sample_index_in;
      end
   end

   // Samples only come out of the Rice phases
   assert property (@(posedge clock) disable iff (reset)
      result.valid |-> (phase_ff == PH_RZERO || phase_ff == PH_RBITS))
      else $error("sample emitted outside a Rice phase");

   // The final sample of a block returns the decoder to the header
   assert property (@(posedge clock) disable iff (reset)
      (result.valid && result.last) |=> (phase_ff == PH_ORDER))
      else $error("no header expected after the last sample");

   // Inside a block the partition index stays within the partition count
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_ORDER && phase_ff != PH_PARAM)
         |-> ({1'b0, partition_index_ff} < part_count))
      else $error("partition index beyond the partition count");

   // The held order is clamped
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_ORDER && accept && cnt_inc >= 6'(ORDER_BITS))
         |=> (order_held_ff <= 4'(ORDER_MAX)))
      else $error("partition order not clamped");

endmodule

// ===== sv/rrd_out_stage.sv =====
module rrd_out_stage
   import rrd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       accept,
   input  result_type                 result,
   output logic                       in_stall,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_sample,
   output logic                       rsp_last
);

   logic                       valid_ff;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic                       last_ff;

   // Hold the input only while a result waits and the consumer stalls
   assign in_stall = valid_ff && rsp_stall;

   // Load a new result, or drop the old one once it has transferred
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (accept && result.valid) begin
         valid_ff <= 1'b1;
      end else if (valid_ff && !rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && result.valid) begin
         sample_ff <= result.sample;
         last_ff   <= result.last;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_sample = sample_ff;
   assign rsp_last   = last_ff;

endmodule

// ===== sv/partitioned_recursive_rice_decoder.sv =====
// A sample appears on rsp_ in the cycle after the transfer of its final code bit.
// Throughput: one code bit per cycle; header and parameter bits produce no result.
// The next bit waits while a finished sample sits in the output register and rsp_stall is high.
// Reset (synchronous, active high): header phase, all counters zero, block_length 1024,
// output register empty.
module partitioned_recursive_rice_decoder
   import rrd_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [LEN_W-1:0]           csr_wr_data,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_bit_req,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_sample,
   output logic                       rsp_last
);

   logic       accept;
   result_type result;

   assign accept = req_valid && !req_stall;

   rrd_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .code_bit    (req_bit_req),
      .result      (result)
   );

   rrd_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .result     (result),
      .in_stall   (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_sample (rsp_sample),
      .rsp_last   (rsp_last)
   );

endmodule
